// ===== design/nearest_facet_search_defines.svh =====
// ----------------------------------------------------------------------------
// nearest_facet_search_defines.svh
// Assertion macros for the nearest facet search block.
// ----------------------------------------------------------------------------
`ifndef NEAREST_FACET_SEARCH_DEFINES_SVH
`define NEAREST_FACET_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define NFS_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("nearest_facet_search: check failed");
`define NFS_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge aclk) prop) \
        else $error("nearest_facet_search: reset check failed");
`else
`define NFS_ASSERT(lbl, prop)
`define NFS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== design/nfs_pkg.sv =====
// ----------------------------------------------------------------------------
// nfs_pkg
// Types and constants shared by the nearest facet search block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nfs_pkg;

    localparam int WORDS_PER_FACET = 12;
    localparam int DIV_BITS        = 48;
    localparam logic OP_LOAD       = 1'b0;
    localparam logic OP_QUERY      = 1'b1;

    localparam logic [1:0] CFG_TOLERANCE   = 2'd0;
    localparam logic [1:0] CFG_LARGE_DIST  = 2'd1;
    localparam logic [1:0] CFG_FACET_COUNT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_LOAD,
        ST_DIFF,
        ST_DIST,
        ST_JUDGE,
        ST_PROJ,
        ST_PREP,
        ST_BARY,
        ST_DIVCHK,
        ST_DIV,
        ST_TEST,
        ST_NEXT,
        ST_OUT
    } nfs_state_t;

endpackage

// ===== design/nearest_facet_search.sv =====
// ----------------------------------------------------------------------------
// nearest_facet_search
// Nearest triangular facet to a query point, signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Loads are written only while idle and return no beat. A query walks the
// loaded facets with one shared 32x32 multiplier, a shared saturating
// subtractor and a one-bit-per-cycle divider. A facet rejected on distance
// skips the barycentric test, whose cost is dominated by two 48-bit
// divisions. The second pass, run only when the first finds nothing, tests
// distance only. The 12 facet words are read one per cycle from the single
// read port of the facet RAM.
`timescale 1ns / 1ps
`include "nearest_facet_search_defines.svh"

module nearest_facet_search
    import nfs_pkg::*;
#(
    parameter int MAX_FACETS = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_opcode,
    input  logic [9:0]         s_facet_slot,
    input  logic [3:0]         s_word_select,
    input  logic signed [31:0] s_word_value,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_found,
    output logic [9:0]         m_nearest_index,
    output logic [30:0]        m_distance,
    output logic               m_projection_inside
);

    localparam int DEPTH = MAX_FACETS * WORDS_PER_FACET;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = $clog2(MAX_FACETS + 1);
    localparam logic signed [49:0] S32_MAX = 50'sd2147483647;
    localparam logic signed [49:0] S32_MIN = -50'sd2147483648;

    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        if (v > S32_MAX) begin
            return 32'sh7FFFFFFF;
        end else if (v < S32_MIN) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic [31:0] abs32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic logic [3:0] vtx(input logic [1:0] axis, input int i);
        return 4'(3 * int'(axis) + i);
    endfunction

    // configuration
    logic [15:0]   tol_reg;
    logic [30:0]   large_reg;
    logic [10:0]   count_reg;

    nfs_state_t    state_reg, state_next;
    logic [3:0]    ld_cnt_reg, ld_cnt_next;
    logic [2:0]    step_reg, step_next;
    logic [NW-1:0] n_reg, n_next, nf_reg, nf_next;
    logic [AW-1:0] base_reg, base_next;
    logic          pass2_reg, pass2_next;
    logic          hit_reg, hit_next;
    logic          first_reg, first_next;
    logic [9:0]    best_reg, best_next;
    logic [30:0]   dmin_reg, dmin_next;
    logic [5:0]    div_cnt_reg, div_cnt_next;
    logic          dsel_reg, dsel_next;

    logic signed [31:0] p_reg [3], p_next [3];
    logic signed [31:0] fw_reg [WORDS_PER_FACET], fw_next [WORDS_PER_FACET];
    logic signed [31:0] t_reg [6], t_next [6];
    logic signed [31:0] q_reg [2], q_next [2];
    logic signed [31:0] r_reg [3], r_next [3];
    logic signed [49:0] acc_reg, acc_next;
    logic signed [47:0] hold_reg, hold_next;
    logic signed [31:0] d_reg, d_next;
    logic [30:0]        ad_reg, ad_next;
    logic [1:0]         ax_reg, ax_next, bx_reg, bx_next;
    logic signed [63:0] prod_reg;
    logic [32:0]        rem_reg, rem_next;
    logic [47:0]        quo_reg, quo_next;
    logic [31:0]        dv_reg, dv_next;
    logic               neg_reg, neg_next;
    logic signed [48:0] l1_reg, l1_next;

    logic signed [31:0] mul_a, mul_b, sub_a, sub_b, sub_res, d_c;
    logic signed [47:0] prod_fl;
    logic signed [48:0] div_res;
    logic signed [51:0] l3, ntol;
    logic [30:0]        ad_c;
    logic [32:0]        r2;
    logic [2:0]         sm1;
    logic [1:0]         axis_s, axis_p;
    logic               wr_en, rd_en, load_ok;
    logic [AW-1:0]      wr_addr, rd_addr;
    logic [31:0]        rd_data;

    nfs_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_word_value),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cfg_ready = 1'b1;
    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = (state_reg == ST_OUT);
    assign m_found   = hit_reg;
    assign m_nearest_index     = hit_reg ? best_reg : 10'd0;
    assign m_distance          = hit_reg ? dmin_reg : 31'd0;
    assign m_projection_inside = first_reg;

    assign load_ok = (32'(s_facet_slot) < MAX_FACETS)
                   && (32'(s_word_select) < WORDS_PER_FACET);
    assign wr_addr = AW'(32'(s_facet_slot) * WORDS_PER_FACET + 32'(s_word_select));
    assign wr_en   = s_valid && s_ready && (s_opcode == OP_LOAD) && load_ok;
    assign rd_addr = base_reg + AW'(ld_cnt_reg);
    assign rd_en   = (state_reg == ST_LOAD) && (ld_cnt_reg < 4'd12);

    assign prod_fl = $signed(prod_reg[63:16]);
    assign sub_res = sat32(50'(sub_a) - 50'(sub_b));
    assign d_c     = sat32(acc_reg);
    assign ad_c    = (d_c == 32'sh80000000) ? 31'h7FFFFFFF : 31'(abs32(d_c));
    assign div_res = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign r2      = {rem_reg[31:0], quo_reg[47]};
    assign sm1     = step_reg - 3'd1;
    assign axis_s  = (step_reg == 3'd0) ? ax_reg : bx_reg;
    assign axis_p  = (sm1 == 3'd0) ? ax_reg : bx_reg;
    assign l3      = 52'sd65536 - 52'(l1_reg) - 52'(div_res);
    assign ntol    = 52'sd0 - $signed({36'b0, tol_reg});

    always_comb begin
        state_next  = state_reg;
        ld_cnt_next = ld_cnt_reg;
        step_next   = step_reg;
        n_next      = n_reg;
        nf_next     = nf_reg;
        base_next   = base_reg;
        pass2_next  = pass2_reg;
        hit_next    = hit_reg;
        first_next  = first_reg;
        best_next   = best_reg;
        dmin_next   = dmin_reg;
        div_cnt_next = div_cnt_reg;
        dsel_next   = dsel_reg;
        p_next      = p_reg;
        fw_next     = fw_reg;
        t_next      = t_reg;
        q_next      = q_reg;
        r_next      = r_reg;
        acc_next    = acc_reg;
        hold_next   = hold_reg;
        d_next      = d_reg;
        ad_next     = ad_reg;
        ax_next     = ax_reg;
        bx_next     = bx_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        dv_next     = dv_reg;
        neg_next    = neg_reg;
        l1_next     = l1_reg;
        mul_a       = 32'sd0;
        mul_b       = 32'sd0;
        sub_a       = 32'sd0;
        sub_b       = 32'sd0;

        case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_opcode == OP_QUERY) begin
                    p_next[0]  = s_point_x;
                    p_next[1]  = s_point_y;
                    p_next[2]  = s_point_z;
                    nf_next    = (32'(count_reg) > MAX_FACETS) ? NW'(MAX_FACETS)
                                                                : NW'(count_reg);
                    dmin_next  = large_reg;
                    hit_next   = 1'b0;
                    first_next = 1'b0;
                    best_next  = 10'd0;
                    pass2_next = 1'b0;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                n_next      = '0;
                base_next   = '0;
                ld_cnt_next = 4'd0;
                state_next  = (nf_reg == '0) ? ST_OUT : ST_LOAD;
            end
            ST_LOAD: begin
                if (ld_cnt_reg != 4'd0) begin
                    fw_next[ld_cnt_reg - 4'd1] = rd_data;
                end
                if (ld_cnt_reg == 4'd12) begin
                    step_next  = 3'd0;
                    state_next = ST_DIFF;
                end else begin
                    ld_cnt_next = ld_cnt_reg + 4'd1;
                end
            end
            ST_DIFF: begin
                sub_a = p_reg[step_reg[1:0]];
                sub_b = fw_reg[vtx(step_reg[1:0], 0)];
                t_next[step_reg] = sub_res;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd2) begin
                    step_next  = 3'd0;
                    state_next = ST_DIST;
                end
            end
            ST_DIST: begin
                if (step_reg < 3'd3) begin
                    mul_a = fw_reg[4'd9 + 4'(step_reg)];
                    mul_b = t_reg[step_reg];
                end
                if (step_reg != 3'd0) begin
                    acc_next = ((step_reg == 3'd1) ? 50'sd0 : acc_reg) + 50'(prod_fl);
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd3) begin
                    state_next = ST_JUDGE;
                end
            end
            ST_JUDGE: begin
                state_next = ST_NEXT;
                if (!pass2_reg) begin
                    if (!(d_c > 32'sd0) && ad_c < dmin_reg) begin
                        d_next    = d_c;
                        ad_next   = ad_c;
                        step_next = 3'd0;
                        if (abs32(fw_reg[9]) > 32'(tol_reg)) begin
                            ax_next = 2'd1;
                            bx_next = 2'd2;
                        end else if (abs32(fw_reg[10]) > 32'(tol_reg)) begin
                            ax_next = 2'd2;
                            bx_next = 2'd0;
                        end else begin
                            ax_next = 2'd0;
                            bx_next = 2'd1;
                        end
                        state_next = ST_PROJ;
                    end
                end else if (d_c <= $signed({16'b0, tol_reg}) && ad_c < dmin_reg) begin
                    dmin_next = ad_c;
                    best_next = 10'(n_reg);
                    hit_next  = 1'b1;
                end
            end
            ST_PROJ: begin
                if (step_reg < 3'd2) begin
                    mul_a = d_reg;
                    mul_b = fw_reg[4'd9 + 4'(axis_s)];
                end
                if (step_reg != 3'd0) begin
                    q_next[sm1[0]] = sat32(50'(p_reg[axis_p]) - 50'(prod_fl));
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd2) begin
                    step_next  = 3'd0;
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                case (step_reg)
                    3'd0: begin
                        sub_a = fw_reg[vtx(ax_reg, 0)];
                        sub_b = fw_reg[vtx(ax_reg, 2)];
                    end
                    3'd1: begin
                        sub_a = fw_reg[vtx(ax_reg, 1)];
                        sub_b = fw_reg[vtx(ax_reg, 2)];
                    end
                    3'd2: begin
                        sub_a = fw_reg[vtx(bx_reg, 0)];
                        sub_b = fw_reg[vtx(bx_reg, 2)];
                    end
                    3'd3: begin
                        sub_a = fw_reg[vtx(bx_reg, 1)];
                        sub_b = fw_reg[vtx(bx_reg, 2)];
                    end
                    3'd4: begin
                        sub_a = fw_reg[vtx(ax_reg, 2)];
                        sub_b = q_reg[0];
                    end
                    default: begin
                        sub_a = fw_reg[vtx(bx_reg, 2)];
                        sub_b = q_reg[1];
                    end
                endcase
                t_next[step_reg] = sub_res;
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd5) begin
                    step_next  = 3'd0;
                    state_next = ST_BARY;
                end
            end
            ST_BARY: begin
                // t: a13 a23 b13 b23 a3i b3i
                case (step_reg)
                    3'd0: begin mul_a = t_reg[3]; mul_b = t_reg[0]; end
                    3'd1: begin mul_a = t_reg[1]; mul_b = t_reg[2]; end
                    3'd2: begin mul_a = t_reg[1]; mul_b = t_reg[5]; end
                    3'd3: begin mul_a = t_reg[3]; mul_b = t_reg[4]; end
                    3'd4: begin mul_a = t_reg[2]; mul_b = t_reg[4]; end
                    3'd5: begin mul_a = t_reg[0]; mul_b = t_reg[5]; end
                    default: begin mul_a = 32'sd0; mul_b = 32'sd0; end
                endcase
                if (step_reg != 3'd0) begin
                    if (!sm1[0]) begin
                        hold_next = prod_fl;
                    end else begin
                        r_next[sm1[2:1]] = sat32(50'(hold_reg) - 50'(prod_fl));
                    end
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd6) begin
                    state_next = ST_DIVCHK;
                end
            end
            ST_DIVCHK: begin
                if (r_reg[0] == 32'sd0) begin
                    state_next = ST_NEXT;
                end else begin
                    rem_next     = 33'd0;
                    quo_next     = {abs32(r_reg[1]), 16'b0};
                    dv_next      = abs32(r_reg[0]);
                    neg_next     = r_reg[1][31] ^ r_reg[0][31];
                    div_cnt_next = 6'(DIV_BITS);
                    dsel_next    = 1'b0;
                    state_next   = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_cnt_reg != 6'd0) begin
                    if (r2 >= {1'b0, dv_reg}) begin
                        rem_next = r2 - {1'b0, dv_reg};
                        quo_next = {quo_reg[46:0], 1'b1};
                    end else begin
                        rem_next = r2;
                        quo_next = {quo_reg[46:0], 1'b0};
                    end
                    div_cnt_next = div_cnt_reg - 6'd1;
                end else if (!dsel_reg) begin
                    l1_next      = div_res;
                    rem_next     = 33'd0;
                    quo_next     = {abs32(r_reg[2]), 16'b0};
                    neg_next     = r_reg[2][31] ^ r_reg[0][31];
                    div_cnt_next = 6'(DIV_BITS);
                    dsel_next    = 1'b1;
                end else begin
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (52'(l1_reg) > ntol && 52'(div_res) > ntol && l3 > ntol) begin
                    dmin_next  = ad_reg;
                    best_next  = 10'(n_reg);
                    hit_next   = 1'b1;
                    first_next = 1'b1;
                end
                state_next = ST_NEXT;
            end
            ST_NEXT: begin
                ld_cnt_next = 4'd0;
                n_next      = n_reg + NW'(1);
                base_next   = base_reg + AW'(WORDS_PER_FACET);
                state_next  = ST_LOAD;
                if (n_reg + NW'(1) == nf_reg) begin
                    if (!pass2_reg && !hit_reg) begin
                        pass2_next = 1'b1;
                        n_next     = '0;
                        base_next  = '0;
                    end else begin
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            tol_reg   <= 16'd66;
            large_reg <= 31'h7FFFFFFF;
            count_reg <= 11'd0;
            hit_reg   <= 1'b0;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            hit_reg   <= hit_next;
            first_reg <= first_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TOLERANCE:   tol_reg   <= cfg_data[15:0];
                    CFG_LARGE_DIST:  large_reg <= cfg_data[30:0];
                    CFG_FACET_COUNT: count_reg <= cfg_data[10:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        ld_cnt_reg  <= ld_cnt_next;
        step_reg    <= step_next;
        n_reg       <= n_next;
        nf_reg      <= nf_next;
        base_reg    <= base_next;
        pass2_reg   <= pass2_next;
        best_reg    <= best_next;
        dmin_reg    <= dmin_next;
        div_cnt_reg <= div_cnt_next;
        dsel_reg    <= dsel_next;
        p_reg       <= p_next;
        fw_reg      <= fw_next;
        t_reg       <= t_next;
        q_reg       <= q_next;
        r_reg       <= r_next;
        acc_reg     <= acc_next;
        hold_reg    <= hold_next;
        d_reg       <= d_next;
        ad_reg      <= ad_next;
        ax_reg      <= ax_next;
        bx_reg      <= bx_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        dv_reg      <= dv_next;
        neg_reg     <= neg_next;
        l1_reg      <= l1_next;
        prod_reg    <= mul_a * mul_b;
    end

    `NFS_ASSERT(a_busy_while_out, m_valid |-> !s_ready)
    `NFS_ASSERT(a_inside_found, m_valid && m_projection_inside |-> m_found)
    `NFS_ASSERT(a_dist_bound, m_valid && m_found |-> m_distance < large_reg)
    `NFS_ASSERT(a_div_hold, state_reg == ST_DIV && div_cnt_reg != 6'd0 |=> state_reg == ST_DIV)
    `NFS_ASSERT_ALWAYS(a_reset_quiet, !aresetn |=> !m_valid)

endmodule

// ===== design/nfs_ram.sv =====
// ----------------------------------------------------------------------------
// nfs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nfs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 12288
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== test/nfs_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfs_checker
// Watches the config, request and result channels of nearest_facet_search,
// keeps a shadow facet table and register set, predicts every query answer
// and compares each result beat against the oldest prediction.
// ----------------------------------------------------------------------------

module nfs_checker
    import nfs_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_opcode,
    input  logic [9:0]         s_facet_slot,
    input  logic [3:0]         s_word_select,
    input  logic signed [31:0] s_word_value,
    input  logic signed [31:0] s_point_x,
    input  logic signed [31:0] s_point_y,
    input  logic signed [31:0] s_point_z,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic               m_found,
    input  logic [9:0]         m_nearest_index,
    input  logic [30:0]        m_distance,
    input  logic               m_projection_inside,
    output int                 errors,
    output int                 pending,
    output int                 n_first,
    output int                 n_second,
    output int                 n_miss
);

    localparam int TABLE_FACETS = 1024;

    typedef struct packed {
        logic        found;
        logic [9:0]  index;
        logic [30:0] distance;
        logic        first_pass;
    } answer_t;

    logic signed [31:0] facet_mem [0:TABLE_FACETS*WORDS_PER_FACET-1];
    longint             tol_q, bound_q;
    int unsigned        count_q;
    answer_t            answers [$];

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint mag(longint v);
        longint m;
        m = (v < 0) ? -v : v;
        return (m > 64'sd2147483647) ? 64'sd2147483647 : m;
    endfunction

    function automatic longint fw(int f, int w);
        return longint'(facet_mem[f*WORDS_PER_FACET + w]);
    endfunction

    function automatic bit bary_inside(longint a0, longint a1, longint a2,
                                       longint b0, longint b1, longint b2,
                                       longint ai, longint bi);
        longint a13, a23, b13, b23, a3i, b3i, den, n1, n2, l1, l2, l3;
        a13 = sat32(a0 - a2); a23 = sat32(a1 - a2);
        b13 = sat32(b0 - b2); b23 = sat32(b1 - b2);
        a3i = sat32(a2 - ai); b3i = sat32(b2 - bi);
        den = sat32(qmul(b23, a13) - qmul(a23, b13));
        n1  = sat32(qmul(a23, b3i) - qmul(b23, a3i));
        n2  = sat32(qmul(b13, a3i) - qmul(a13, b3i));
        if (den == 0) return 1'b0;
        l1 = (n1 * 65536) / den;
        l2 = (n2 * 65536) / den;
        l3 = 65536 - l1 - l2;
        return l1 > -tol_q && l2 > -tol_q && l3 > -tol_q;
    endfunction

    function automatic longint plane_dist(int f, longint p[3]);
        longint s;
        s = 0;
        for (int d = 0; d < 3; d++) s += qmul(fw(f, 9 + d), sat32(p[d] - fw(f, 3*d)));
        return sat32(s);
    endfunction

    function automatic answer_t nearest_facet(longint p[3]);
        answer_t r;
        longint  dmin, d, ad;
        longint  v [3][3];
        longint  q [3];
        int      nf, best;
        bit      hit, first, ok;
        dmin = bound_q; best = 0; hit = 0; first = 0;
        nf = (count_q > TABLE_FACETS) ? TABLE_FACETS : count_q;
        for (int n = 0; n < nf; n++) begin
            d = plane_dist(n, p);
            ad = mag(d);
            if (d > 0 || ad >= dmin) continue;
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) v[k][i] = fw(n, 3*k + i);
                q[k] = sat32(p[k] - qmul(d, fw(n, 9 + k)));
            end
            if (mag(fw(n, 9)) > tol_q)
                ok = bary_inside(v[1][0], v[1][1], v[1][2], v[2][0], v[2][1], v[2][2],
                                 q[1], q[2]);
            else if (mag(fw(n, 10)) > tol_q)
                ok = bary_inside(v[2][0], v[2][1], v[2][2], v[0][0], v[0][1], v[0][2],
                                 q[2], q[0]);
            else
                ok = bary_inside(v[0][0], v[0][1], v[0][2], v[1][0], v[1][1], v[1][2],
                                 q[0], q[1]);
            if (ok) begin
                dmin = ad; best = n; hit = 1; first = 1;
            end
        end
        if (!hit) begin
            for (int n = 0; n < nf; n++) begin
                d = plane_dist(n, p);
                ad = mag(d);
                if (d > tol_q) continue;
                if (ad < dmin) begin
                    dmin = ad; best = n; hit = 1;
                end
            end
        end
        r.found      = hit;
        r.index      = hit ? best[9:0] : '0;
        r.distance   = hit ? dmin[30:0] : '0;
        r.first_pass = first;
        return r;
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    assign pending = answers.size();

    initial begin
        errors = 0; n_first = 0; n_second = 0; n_miss = 0;
    end

    always @(posedge aclk) begin
        longint  pt [3];
        answer_t want;
        if (!aresetn) begin
            tol_q   <= 66;
            bound_q <= 64'sd2147483647;
            count_q <= 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_TOLERANCE:   tol_q   <= longint'(cfg_data[15:0]);
                    CFG_LARGE_DIST:  bound_q <= longint'(cfg_data[30:0]);
                    CFG_FACET_COUNT: count_q <= 32'(cfg_data[10:0]);
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_opcode == OP_LOAD) begin
                    if (s_word_select < WORDS_PER_FACET)
                        facet_mem[s_facet_slot*WORDS_PER_FACET + s_word_select] = s_word_value;
                end else begin
                    pt[0] = longint'(s_point_x);
                    pt[1] = longint'(s_point_y);
                    pt[2] = longint'(s_point_z);
                    answers.push_back(nearest_facet(pt));
                end
            end
            if (m_valid && m_ready) begin
                if (answers.size() == 0) begin
                    $display("[%0t] result beat with nothing expected", $time);
                    errors++;
                end else begin
                    want = answers.pop_front();
                    if (m_found != want.found) report("found", m_found, want.found);
                    if (m_nearest_index != want.index)
                        report("nearest_index", m_nearest_index, want.index);
                    if (m_distance != want.distance)
                        report("distance", m_distance, want.distance);
                    if (m_projection_inside != want.first_pass)
                        report("projection_inside", m_projection_inside, want.first_pass);
                    if (!want.found) n_miss++;
                    else if (want.first_pass) n_first++;
                    else n_second++;
                end
            end
        end
    end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for nearest_facet_search: loads a small facet table,
// runs directed and random queries under several register settings with
// random gaps and back-pressure. Checking is done by nfs_checker.
// ----------------------------------------------------------------------------

module testbench;
    import nfs_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam int         LIMIT     = 4000000;
    localparam int         NSMALL    = 4;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_opcode = OP_LOAD;
    logic [9:0]         s_facet_slot = '0;
    logic [3:0]         s_word_select = '0;
    logic signed [31:0] s_word_value = '0;
    logic signed [31:0] s_point_x = '0;
    logic signed [31:0] s_point_y = '0;
    logic signed [31:0] s_point_z = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic               m_found;
    logic [9:0]         m_nearest_index;
    logic [30:0]        m_distance;
    logic               m_projection_inside;

    int errors, pending, n_first, n_second, n_miss;
    int cycles = 0;
    bit calm = 0;
    logic signed [31:0] geo [0:1023][0:11];

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    nearest_facet_search i_dut (.*);

    nfs_checker i_checker (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("** nearest_facet_search: FAILED **");
            $finish;
        end
    end

    function automatic int gap();
        return calm ? 0 : $urandom_range(0, 16);
    endfunction

    // result side: random stall before each beat
    initial begin
        int g;
        @(posedge aresetn);
        forever begin
            g = gap();
            if (g > 0) begin
                m_ready <= 1'b0;
                repeat (g) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic push(logic op, int slot, int ws, logic [31:0] wv,
                        logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        int g;
        g = gap();
        if (g > 0) begin
            s_valid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op; s_facet_slot <= 10'(slot); s_word_select <= 4'(ws);
        s_word_value <= wv;
        s_point_x <= px; s_point_y <= py; s_point_z <= pz;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (16) @(posedge aclk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] small_coord();
        return $urandom_range(0, 524288) - 262144;
    endfunction

    task automatic make_facet(int f);
        int kind, ax;
        kind = $urandom_range(0, 9);
        for (int w = 0; w < 9; w++) geo[f][w] = small_coord();
        if (kind == 0) begin
            for (int w = 0; w < 12; w++) geo[f][w] = $urandom();
        end else begin
            if (kind == 1) begin
                geo[f][2] = geo[f][0]; geo[f][5] = geo[f][3]; geo[f][8] = geo[f][6];
            end
            if (kind == 2) begin
                for (int w = 9; w < 12; w++) geo[f][w] = $urandom_range(0, 131072) - 65536;
            end else begin
                ax = $urandom_range(0, 2);
                for (int w = 9; w < 12; w++) geo[f][w] = 0;
                geo[f][9 + ax] = $urandom_range(0, 1) ? 65536 : -65536;
            end
        end
    endtask

    task automatic load_facet(int f);
        for (int w = 0; w < 12; w++)
            push(OP_LOAD, f, w, geo[f][w], $urandom(), $urandom(), $urandom());
    endtask

    task automatic aim_query(int f);
        longint c [3];
        logic [31:0] pq [3];
        for (int a = 0; a < 3; a++) begin
            c[a] = (longint'(geo[f][3*a]) + longint'(geo[f][3*a+1])
                    + longint'(geo[f][3*a+2])) / 3;
            pq[a] = 32'(c[a] + longint'($urandom_range(0, 131072)) - 64'sd65536);
        end
        if ($urandom_range(0, 7) == 0) begin
            pq[0] = $urandom(); pq[1] = $urandom(); pq[2] = $urandom();
        end
        push(OP_QUERY, $urandom(), $urandom(), $urandom(), pq[0], pq[1], pq[2]);
    endtask

    initial begin
        logic [31:0] tol, bound;
        int cnt;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty table, one flat triangle, hits, misses, an ignored load and a load to the last slot
        calm = 1;
        push(OP_QUERY, 0, 0, 0, 0, 0, 0);
        geo[0] = '{0, 65536, 0, 0, 0, 65536, 0, 0, 0, 0, 0, 65536};
        load_facet(0);
        push(OP_LOAD, 1023, 15, 32'hFFFF_FFFF, 0, 0, 0);
        push(OP_LOAD, 1023, 11, 32'h8000_0000, 0, 0, 0);
        drain();
        cfg_write(CFG_FACET_COUNT, 1);
        cfg_write(CFG_SPARE, 32'hFFFF_FFFF);
        push(OP_QUERY, 0, 0, 0, 16384, 16384, -65536);
        push(OP_QUERY, 0, 0, 0, 327680, 327680, -65536);
        push(OP_QUERY, 0, 0, 0, 16384, 16384, 65536);
        push(OP_QUERY, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push(OP_QUERY, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        push(OP_QUERY, 0, 0, 0, 32'hFFFF_FFFF, 0, 32'h8000_0000);
        drain();

        // random phases with varied register settings
        calm = 0;
        for (int f = 0; f < NSMALL; f++) begin
            make_facet(f);
            load_facet(f);
        end
        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: begin tol = 0; bound = 32'h7FFF_FFFF; end
                1: begin tol = 65535; bound = 32'h7FFF_FFFF; end
                2: begin tol = 66; bound = 0; end
                3: begin tol = 65535; bound = 32'hFFFF_FFFF; end
                default: begin tol = $urandom_range(0, 65535); bound = $urandom(); end
            endcase
            cnt = (ph == 5) ? 0 : $urandom_range(1, NSMALL);
            calm = (ph == 6);
            cfg_write(CFG_TOLERANCE, tol);
            cfg_write(CFG_LARGE_DIST, bound);
            cfg_write(CFG_FACET_COUNT, cnt);
            for (int i = 0; i < 9; i++) begin
                if ($urandom_range(0, 9) < 7) begin
                    aim_query($urandom_range(0, NSMALL - 1));
                end else if ($urandom_range(0, 3) == 0) begin
                    push(OP_LOAD, $urandom(), 12 + $urandom_range(0, 3), $urandom(),
                         $urandom(), $urandom(), $urandom());
                end else begin
                    int f, w;
                    f = $urandom_range(0, NSMALL - 1);
                    w = $urandom_range(0, 11);
                    geo[f][w] = (w < 9) ? small_coord() : $urandom();
                    push(OP_LOAD, f, w, geo[f][w], $urandom(), $urandom(), $urandom());
                end
            end
        end
        drain();

        $display("covered %0d first-pass hits, %0d second-pass hits, %0d misses",
                 n_first, n_second, n_miss);
        $display("register sweeps over tables of 0 to %0d facets, %0d mismatches",
                 NSMALL, errors);
        if (errors == 0) begin
            $display("** nearest_facet_search: PASSED **");
        end else begin
            $display("** nearest_facet_search: FAILED **");
        end
        $finish;
    end

endmodule
